@@ hdl/acdg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acdg_pkg;

  // Defaults for the top-level parameter and fixed limits of the command format.
  localparam int SECTOR_BYTES        = 512;
  localparam int MAX_ENTRIES         = 4;
  localparam int MAX_COMMAND_SECTORS = 256;

  localparam logic [7:0]  DEV_BASE    = 8'hE0;
  localparam logic [28:0] LBA28_SPAN  = 29'h1000_0000;
  localparam logic [16:0] BOUNDARY    = 17'h1_0000;
  localparam logic [32:0] WINDOW_TOP  = 33'h1_0000_0000;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_REQ    = 2'd1;
  localparam logic [1:0] STATUS_BEYOND     = 2'd2;
  localparam logic [1:0] STATUS_WINDOW     = 2'd3;

  typedef struct packed {
    logic [31:0] start_block;
    logic [8:0]  sector_total;
    logic [39:0] target_address;
  } in_t;

  typedef struct packed {
    logic [1:0]  status_code;
    logic [7:0]  device_select;
    logic [7:0]  count_byte;
    logic [7:0]  block_low;
    logic [7:0]  block_mid;
    logic [7:0]  block_high;
    logic [31:0] entry_address;
    logic [15:0] entry_length;
    logic        entry_last;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic eval;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic err;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/acdg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acdg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire acdg_pkg::sts_t sts,
  output acdg_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EVAL,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // A rejected command produces its single error word right here.
        if (sts.err) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        if (sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.calc  = (state_r == ST_CALC);
  assign cmd.eval  = (state_r == ST_EVAL);
  assign cmd.emit  = (state_r == ST_EMIT);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/acdg_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acdg_dp #(
  parameter int SECTOR_BYTES = acdg_pkg::SECTOR_BYTES
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire acdg_pkg::cmd_t cmd,
  input  wire acdg_pkg::in_t in_word,
  input  wire logic          cfg_we,
  input  wire logic [28:0]   cfg_wdata,
  output acdg_pkg::sts_t     sts,
  output acdg_pkg::out_t     out_word
);

  localparam int TOT_W = 9 + $clog2(SECTOR_BYTES + 1);
  localparam int CNT_W = TOT_W - 15;
  localparam logic [TOT_W-1:0] SB_W      = TOT_W'(SECTOR_BYTES);
  localparam logic [8:0]       MAX_SECS  = 9'(acdg_pkg::MAX_COMMAND_SECTORS);
  localparam logic [CNT_W-1:0] MAX_ENT_W = CNT_W'(acdg_pkg::MAX_ENTRIES);

  logic [28:0]      disk_size_r;

  logic [31:0]      lba_r;
  logic [8:0]       secs_r;
  logic [39:0]      addr_r;

  logic [TOT_W-1:0] total_r, total_nxt;
  logic [28:0]      lba_end_r, lba_end_nxt;
  logic [28:0]      cap_r, cap_nxt;
  logic             bad_req_r, bad_req_nxt;

  logic [31:0]      cur_r, cur_nxt;
  logic [TOT_W-1:0] rem_r, rem_nxt;

  acdg_pkg::out_t   out_r, out_nxt;

  logic             beyond;
  logic [32:0]      win_end;
  logic             window_bad;
  logic [TOT_W:0]   off_end;
  logic             overflow;
  logic             err;
  logic [1:0]       err_code;

  logic [16:0]      room;
  logic [TOT_W-1:0] room_w;
  logic             last;
  logic [TOT_W-1:0] chunk;

  // First stage: sector byte count, LBA end, capacity clamp and the request check.
  always_comb begin
    total_nxt   = TOT_W'(secs_r) * SB_W;
    lba_end_nxt = {1'b0, lba_r[27:0]} + 29'(secs_r);
    cap_nxt     = (disk_size_r > acdg_pkg::LBA28_SPAN) ? acdg_pkg::LBA28_SPAN : disk_size_r;
    bad_req_nxt = (secs_r == 9'd0) || (secs_r > MAX_SECS) || (lba_r[31:28] != 4'd0);
  end

  // Second stage: the remaining checks and the entry count check.
  always_comb begin
    beyond     = (cap_r != 29'd0) && (lba_end_r > cap_r);
    win_end    = {1'b0, addr_r[31:0]} + 33'(total_r);
    window_bad = (addr_r[39:32] != 8'd0) || (win_end > acdg_pkg::WINDOW_TOP);
    // Offset of the final byte from the 64 KiB page of the first one.
    off_end    = (TOT_W+1)'(addr_r[15:0]) + (TOT_W+1)'(total_r) - (TOT_W+1)'(1);
    overflow   = off_end[TOT_W:16] >= MAX_ENT_W;
    err        = bad_req_r || (lba_end_r > acdg_pkg::LBA28_SPAN) || beyond || window_bad ||
                 overflow;
    if (bad_req_r || (lba_end_r > acdg_pkg::LBA28_SPAN)) begin
      err_code = acdg_pkg::STATUS_BAD_REQ;
    end else if (beyond) begin
      err_code = acdg_pkg::STATUS_BEYOND;
    end else begin
      err_code = acdg_pkg::STATUS_WINDOW;
    end
  end

  // Entry split: cut at the next 64 KiB boundary.
  always_comb begin
    room   = acdg_pkg::BOUNDARY - {1'b0, cur_r[15:0]};
    room_w = TOT_W'(room);
    last   = rem_r <= room_w;
    chunk  = last ? rem_r : room_w;
  end

  always_comb begin
    cur_nxt = cur_r;
    rem_nxt = rem_r;
    out_nxt = out_r;
    if (cmd.eval) begin
      cur_nxt = addr_r[31:0];
      rem_nxt = total_r;
      if (err) begin
        out_nxt             = '0;
        out_nxt.status_code = err_code;
        out_nxt.entry_last  = 1'b1;
      end
    end
    if (cmd.emit) begin
      cur_nxt                = cur_r + 32'(chunk);
      rem_nxt                = rem_r - chunk;
      out_nxt.status_code    = acdg_pkg::STATUS_OK;
      out_nxt.device_select  = acdg_pkg::DEV_BASE | {4'd0, lba_r[27:24]};
      out_nxt.count_byte     = secs_r[7:0];
      out_nxt.block_low      = lba_r[7:0];
      out_nxt.block_mid      = lba_r[15:8];
      out_nxt.block_high     = lba_r[23:16];
      out_nxt.entry_address  = cur_r;
      out_nxt.entry_length   = chunk[15:0];
      out_nxt.entry_last     = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r <= '0;
    end else if (cfg_we) begin
      disk_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lba_r  <= in_word.start_block;
      secs_r <= in_word.sector_total;
      addr_r <= in_word.target_address;
    end
    if (cmd.calc) begin
      total_r   <= total_nxt;
      lba_end_r <= lba_end_nxt;
      cap_r     <= cap_nxt;
      bad_req_r <= bad_req_nxt;
    end
    cur_r <= cur_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

  assign sts.err  = err;
  assign sts.last = last;
  assign out_word = out_r;

endmodule

`default_nettype wire

@@ hdl/ata_dma_command_descriptor_gen.sv @@
// An error word is registered in the eval state; table entries are registered in the emit state.
// A new command is taken only once the controller is back in idle;
// the entry loop in the datapath sends one word per cycle.
// Reset (rst_n low, synchronous) returns the controller to idle and the disk size to 0.
// Words are shown for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module ata_dma_command_descriptor_gen #(
  parameter int SECTOR_BYTES = acdg_pkg::SECTOR_BYTES
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire acdg_pkg::in_t in_word,
  output logic               out_valid,
  output acdg_pkg::out_t     out_word,
  input  wire logic          cfg_we,
  input  wire logic [28:0]   cfg_wdata
);

  acdg_pkg::cmd_t cmd;
  acdg_pkg::sts_t sts;

  acdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  acdg_dp #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .out_word  (out_word)
  );

  // The final word of a command is shown only once the controller is idle again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.entry_last |-> !busy)
    else $error("last word shown while busy");

  // An error is always a single, final word.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status_code != acdg_pkg::STATUS_OK) |-> out_word.entry_last)
    else $error("error word not marked last");

  // Table entries follow each other without gaps.
  a_entries_packed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.entry_last |=> out_valid)
    else $error("gap inside a table");

  // A taken command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

endmodule

`default_nettype wire

@@ dv/acdg_descriptor_checker.sv @@
`timescale 1ns / 1ps

module acdg_descriptor_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  acdg_pkg::in_t  in_word,
  input  logic           out_valid,
  input  acdg_pkg::out_t out_word,
  input  logic           cfg_we,
  input  logic [28:0]    cfg_wdata,
  output int             errors,
  output int             pending
);

  acdg_pkg::out_t expected_words[$];
  logic [28:0]    disk_size_cur;

  // Works out the words that one read command should produce and queues them.
  function automatic void build_descriptors(input acdg_pkg::in_t cmd, input logic [28:0] disk);
    longint unsigned lba, secs, addr, cap, total, room, chunk;
    logic [1:0] code;
    acdg_pkg::out_t word;
    acdg_pkg::out_t entries[$];
    lba  = cmd.start_block;
    secs = cmd.sector_total;
    addr = cmd.target_address;
    cap  = disk;
    if (cap > acdg_pkg::LBA28_SPAN) cap = acdg_pkg::LBA28_SPAN;
    code = acdg_pkg::STATUS_OK;
    if (secs == 0 || secs > acdg_pkg::MAX_COMMAND_SECTORS || lba >= acdg_pkg::LBA28_SPAN ||
        secs > acdg_pkg::LBA28_SPAN - lba) begin
      code = acdg_pkg::STATUS_BAD_REQ;
    end else if (cap != 0 && (lba >= cap || secs > cap - lba)) begin
      code = acdg_pkg::STATUS_BEYOND;
    end else begin
      total = secs * acdg_pkg::SECTOR_BYTES;
      if (addr > 64'hFFFF_FFFF || total > acdg_pkg::WINDOW_TOP - addr)
        code = acdg_pkg::STATUS_WINDOW;
      while (code == acdg_pkg::STATUS_OK && total != 0) begin
        room  = acdg_pkg::BOUNDARY - (addr & 64'hFFFF);
        chunk = (total < room) ? total : room;
        if (entries.size() >= acdg_pkg::MAX_ENTRIES) begin
          code = acdg_pkg::STATUS_WINDOW;
        end else begin
          word               = '0;
          word.status_code   = acdg_pkg::STATUS_OK;
          word.device_select = acdg_pkg::DEV_BASE | {4'h0, cmd.start_block[27:24]};
          word.count_byte    = cmd.sector_total[7:0];
          word.block_low     = cmd.start_block[7:0];
          word.block_mid     = cmd.start_block[15:8];
          word.block_high    = cmd.start_block[23:16];
          word.entry_address = addr[31:0];
          // A full 64 KiB entry wraps to a length code of zero.
          word.entry_length  = chunk[15:0];
          entries.push_back(word);
          addr  = addr + chunk;
          total = total - chunk;
        end
      end
    end
    if (code != acdg_pkg::STATUS_OK) begin
      word             = '0;
      word.status_code = code;
      word.entry_last  = 1'b1;
      expected_words.push_back(word);
    end else begin
      entries[entries.size() - 1].entry_last = 1'b1;
      foreach (entries[i]) expected_words.push_back(entries[i]);
    end
  endfunction

  task automatic compare_field(input string name, input logic [39:0] exp_v,
                               input logic [39:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_word(input acdg_pkg::out_t got);
    acdg_pkg::out_t exp_w;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t: word with none expected, expected none actual %p", $time, got);
    end else begin
      exp_w = expected_words.pop_front();
      compare_field("status_code",   exp_w.status_code,   got.status_code);
      compare_field("device_select", exp_w.device_select, got.device_select);
      compare_field("count_byte",    exp_w.count_byte,    got.count_byte);
      compare_field("block_low",     exp_w.block_low,     got.block_low);
      compare_field("block_mid",     exp_w.block_mid,     got.block_mid);
      compare_field("block_high",    exp_w.block_high,    got.block_high);
      compare_field("entry_address", exp_w.entry_address, got.entry_address);
      compare_field("entry_length",  exp_w.entry_length,  got.entry_length);
      compare_field("entry_last",    exp_w.entry_last,    got.entry_last);
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    disk_size_cur = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      disk_size_cur = '0;
    end else begin
      if (cfg_we) disk_size_cur = cfg_wdata;
      if (start && !busy) build_descriptors(in_word, disk_size_cur);
      if (out_valid) check_word(out_word);
    end
    pending = expected_words.size();
  end

endmodule

@@ dv/ata_dma_command_descriptor_gen_tb.sv @@
`timescale 1ns / 1ps

module ata_dma_command_descriptor_gen_tb;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  acdg_pkg::in_t  in_word = '0;
  logic           out_valid;
  acdg_pkg::out_t out_word;
  logic           cfg_we = 1'b0;
  logic [28:0]    cfg_wdata = '0;
  int             errors;
  int             pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ata_dma_command_descriptor_gen i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  acdg_descriptor_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic acdg_pkg::in_t make_cmd(input logic [31:0] lba, input logic [8:0] secs,
                                             input logic [39:0] addr);
    acdg_pkg::in_t c;
    c.start_block    = lba;
    c.sector_total   = secs;
    c.target_address = addr;
    return c;
  endfunction

  function automatic acdg_pkg::in_t noise_cmd();
    return make_cmd($urandom, 9'($urandom), {8'($urandom), 32'($urandom)});
  endfunction

  // Mostly well-formed commands, many near the edges of the disk and the 4 GiB window.
  function automatic acdg_pkg::in_t rand_cmd(input logic [28:0] disk);
    longint      lim, near;
    logic [31:0] lba;
    logic [8:0]  secs;
    logic [39:0] addr;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return noise_cmd();
    secs = (pick == 1) ? 9'd256 : 9'($urandom_range(1, 256));
    lim  = (disk == 0 || disk > acdg_pkg::LBA28_SPAN) ? longint'(acdg_pkg::LBA28_SPAN) :
           longint'(disk);
    case ($urandom_range(0, 3))
      0: lba = $urandom_range(0, 1000);
      1: begin
        near = lim - $urandom_range(0, 300);
        lba  = (near < 0) ? 32'd0 : 32'(near);
      end
      default: lba = 32'($urandom % lim);
    endcase
    case ($urandom_range(0, 3))
      0: addr = 40'h1_0000_0000 - 40'($urandom_range(0, 32'h3_0000));
      1: addr = {8'h00, 16'($urandom), 7'($urandom), 9'h000};
      default: addr = {8'h00, 32'($urandom)};
    endcase
    return make_cmd(lba, secs, addr);
  endfunction

  task automatic issue(input acdg_pkg::in_t w);
    @(negedge clk);
    start   = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start   = 1'b0;
    in_word = noise_cmd();
    repeat (n - 1) @(negedge clk);
  endtask

  // The disk size is only changed once every expected word has come out.
  task automatic set_disk(input logic [28:0] v);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [28:0] disk;
    bit          idle_on;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Disk size unknown after reset.
    issue(make_cmd(32'h0, 9'd1, 40'h0));
    issue(make_cmd(32'h0, 9'd256, 40'h0));
    issue(make_cmd(32'h0ABC_DEF1, 9'd256, 40'h00_1234_8000));
    issue(make_cmd(32'h0, 9'd0, 40'h0));
    issue(make_cmd(32'h0, 9'd257, 40'h0));
    issue(make_cmd(32'h0, 9'd511, 40'h0));
    issue(make_cmd(32'h1000_0000, 9'd1, 40'h0));
    issue(make_cmd(32'hFFFF_FFFF, 9'd1, 40'h0));
    issue(make_cmd(32'h0FFF_FFFF, 9'd1, 40'h0));
    issue(make_cmd(32'h0FFF_FFFF, 9'd2, 40'h0));
    issue(make_cmd(32'h0FFF_FF00, 9'd256, 40'h0));
    issue(make_cmd(32'h0FFF_FF01, 9'd256, 40'h0));
    issue(make_cmd(32'h5, 9'd1, 40'hFF_FFFF_FFFF));
    issue(make_cmd(32'h5, 9'd1, 40'h01_0000_0000));
    issue(make_cmd(32'h5, 9'd1, 40'h00_FFFF_FE00));
    issue(make_cmd(32'h5, 9'd2, 40'h00_FFFF_FE00));
    issue(make_cmd(32'h5, 9'd1, 40'h00_FFFF_FFFF));

    set_disk(29'd1000);
    issue(make_cmd(32'd999, 9'd1, 40'h0));
    issue(make_cmd(32'd1000, 9'd1, 40'h0));
    issue(make_cmd(32'd900, 9'd101, 40'h0));
    issue(make_cmd(32'd900, 9'd100, 40'h0));

    // Sizes above the LBA28 span behave as the span itself.
    set_disk(29'h1FFF_FFFF);
    issue(make_cmd(32'h0FFF_FF00, 9'd256, 40'h00_0000_FE00));
    set_disk(29'd1);
    issue(make_cmd(32'h0, 9'd1, 40'h0));
    issue(make_cmd(32'h0, 9'd2, 40'h0));
    issue(make_cmd(32'h1, 9'd1, 40'h0));

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: disk = 29'($urandom_range(1, 4096));
        1: disk = acdg_pkg::LBA28_SPAN;
        2: disk = 29'($urandom);
        default: disk = 29'd0;
      endcase
      set_disk(disk);
      idle_on = 1'b1;
      for (int n = 0; n < 21; n++) begin
        if (n % 8 == 0) idle_on = $urandom_range(0, 2) != 0;
        // No gaps at all in the closing phase.
        if (phase < 4 && idle_on && $urandom_range(0, 2) == 0) pause($urandom_range(1, 17));
        issue(rand_cmd(disk));
      end
    end

    @(negedge clk);
    start = 1'b0;
    for (int w = 0; w < 1000 && pending != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
